FILE: rtl/ir_pulse_distance_decoder_unit_assert.svh
// Assertion macros shared by the IR pulse distance decoder modules.
`ifndef IR_PULSE_DISTANCE_DECODER_UNIT_ASSERT_SVH
`define IR_PULSE_DISTANCE_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define IRPDD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

`define IRPDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`else

`define IRPDD_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define IRPDD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/irpdd_pkg.sv
// Types, constants and codes shared by the IR pulse distance decoder.
package irpdd_pkg;

   localparam int StampW            = 16;
   localparam int ByteW             = 8;
   localparam int BitW              = $clog2(ByteW);
   localparam int CfgW              = 16;
   localparam int CfgCount          = 8;
   localparam int CfgIdxW           = 3;
   localparam int FrameBytesDefault = 4;
   localparam int OutBytes          = 4;
   localparam int QueueDepth        = 2;

   localparam logic [StampW-1:0] OneMax = 16'd2400;

   typedef enum logic [CfgIdxW-1:0] {
      CSR_GAP_RESET_MIN,
      CSR_START_MIN,
      CSR_START_MAX,
      CSR_END_MIN,
      CSR_END_MAX,
      CSR_ZERO_MIN,
      CSR_ZERO_MAX,
      CSR_ONE_MIN
   } csr_index_type;

   localparam logic [CfgW-1:0] CfgReset [CfgCount] = '{
      16'd10500, 16'd8500, 16'd9500, 16'd500,
      16'd700,   16'd1000, 16'd1300, 16'd2000
   };

   typedef enum logic [1:0] {
      CLS_RESTART,
      CLS_END,
      CLS_ZERO,
      CLS_ONE
   } gap_class_type;

   typedef struct packed {
      logic          valid;
      gap_class_type cls;
   } class_entry_type;

endpackage

FILE: rtl/irpdd_classifier.sv
// Front end: holds the window registers and the last stamp, and classifies each gap.
module irpdd_classifier (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_accept,
   input  logic [irpdd_pkg::StampW-1:0]         req_capture_stamp,
   input  logic                                 csr_write,
   input  logic [irpdd_pkg::CfgIdxW-1:0]        csr_index,
   input  logic [irpdd_pkg::CfgW-1:0]           csr_wdata,
   output irpdd_pkg::class_entry_type           push
);
   import irpdd_pkg::*;

   logic [CfgW-1:0]   cfg_ff [CfgCount];
   logic [StampW-1:0] prev_ff;
   logic              have_prev_ff;

   logic [StampW-1:0] gap;
   logic              long_gap;
   logic              is_restart;
   logic              is_end;
   logic              is_zero;
   logic              is_one;

   always_comb begin
      long_gap   = req_capture_stamp < prev_ff;
      gap        = req_capture_stamp - prev_ff;
      // A start burst restarts the frame exactly like a long gap does.
      is_restart = long_gap || (gap > cfg_ff[CSR_GAP_RESET_MIN]) ||
                   ((gap > cfg_ff[CSR_START_MIN]) && (gap < cfg_ff[CSR_START_MAX]));
      is_end     = (gap > cfg_ff[CSR_END_MIN])  && (gap < cfg_ff[CSR_END_MAX]);
      is_zero    = (gap > cfg_ff[CSR_ZERO_MIN]) && (gap < cfg_ff[CSR_ZERO_MAX]);
      is_one     = (gap > cfg_ff[CSR_ONE_MIN])  && (gap < OneMax);

      push.valid = req_accept && have_prev_ff && (is_restart || is_end || is_zero || is_one);
      if (is_restart) begin
         push.cls = CLS_RESTART;
      end else if (is_end) begin
         push.cls = CLS_END;
      end else if (is_zero) begin
         push.cls = CLS_ZERO;
      end else begin
         push.cls = CLS_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CfgCount; i++) begin
            cfg_ff[i] <= CfgReset[i];
         end
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            cfg_ff[csr_index] <= csr_wdata;
         end
         if (req_accept) begin
            prev_ff      <= req_capture_stamp;
            have_prev_ff <= 1'b1;
         end
      end
   end

endmodule

FILE: rtl/irpdd_queue.sv
// Short queue of classified gaps between the front end and the frame engine.
`include "ir_pulse_distance_decoder_unit_assert.svh"

module irpdd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  irpdd_pkg::class_entry_type  push,
   input  logic                        pop,
   output irpdd_pkg::class_entry_type  head,
   output logic                        full
);
   import irpdd_pkg::*;

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   gap_class_type   slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_pop;

   assign full       = (count_ff == CntW'(QueueDepth));
   assign head.valid = (count_ff != '0);
   assign head.cls   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push.valid && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push.valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `IRPDD_ASSERT_IMPLY(a_q_no_overflow, clock, reset, push.valid, !full)
   `IRPDD_ASSERT_IMPLY(a_q_count_bound, clock, reset, 1'b1, count_ff <= CntW'(QueueDepth))

endmodule

FILE: rtl/irpdd_frame.sv
// Back end: assembles frame bytes from queued gaps and holds the result register.
`include "ir_pulse_distance_decoder_unit_assert.svh"

module irpdd_frame #(
   parameter int FRAME_BYTES = irpdd_pkg::FrameBytesDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  irpdd_pkg::class_entry_type     head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [irpdd_pkg::ByteW-1:0]    rsp_address_byte,
   output logic [irpdd_pkg::ByteW-1:0]    rsp_address_inverse,
   output logic [irpdd_pkg::ByteW-1:0]    rsp_command_byte,
   output logic [irpdd_pkg::ByteW-1:0]    rsp_command_inverse,
   output logic                           rsp_command_ok
);
   import irpdd_pkg::*;

   localparam int StoreN = (FRAME_BYTES > OutBytes) ? FRAME_BYTES : OutBytes;
   localparam int PosW   = $clog2(FRAME_BYTES + 1);

   logic [ByteW-1:0] byte_ff [StoreN];
   logic [ByteW-1:0] byte_in [StoreN];
   logic [PosW-1:0]  byte_pos_ff;
   logic [PosW-1:0]  byte_pos_in;
   logic [BitW-1:0]  bit_pos_ff;
   logic [BitW-1:0]  bit_pos_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [ByteW-1:0] out_byte_ff [OutBytes];
   logic             ok_ff;
   logic             frame_full;
   logic             emit;
   logic             shift;
   logic             new_bit;

   assign frame_full = (byte_pos_ff == PosW'(FRAME_BYTES));

   always_comb begin
      pop         = head.valid && (!rsp_valid_ff || !rsp_stall);
      emit        = 1'b0;
      shift       = 1'b0;
      new_bit     = 1'b0;
      byte_pos_in = byte_pos_ff;
      bit_pos_in  = bit_pos_ff;
      byte_in     = byte_ff;

      if (pop) begin
         case (head.cls)
            CLS_RESTART: begin
               byte_pos_in = '0;
               bit_pos_in  = '0;
            end
            CLS_END: begin
               if (frame_full) begin
                  emit        = 1'b1;
                  byte_pos_in = '0;
               end
            end
            CLS_ZERO, CLS_ONE: begin
               // Bits that arrive once the frame is full are dropped.
               shift   = !frame_full;
               new_bit = (head.cls == CLS_ONE);
            end
            default: begin
            end
         endcase
      end

      if (shift) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            if (byte_pos_ff == PosW'(i)) begin
               byte_in[i] = {new_bit, byte_ff[i][ByteW-1:1]};
            end
         end
         if (bit_pos_ff == BitW'(ByteW - 1)) begin
            bit_pos_in  = '0;
            byte_pos_in = byte_pos_ff + 1'b1;
         end else begin
            bit_pos_in  = bit_pos_ff + 1'b1;
         end
      end

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < StoreN; i++) begin
            byte_ff[i] <= '0;
         end
         byte_pos_ff  <= '0;
         bit_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         byte_ff      <= byte_in;
         byte_pos_ff  <= byte_pos_in;
         bit_pos_ff   <= bit_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         for (int i = 0; i < OutBytes; i++) begin
            out_byte_ff[i] <= byte_ff[i];
         end
         ok_ff <= (byte_ff[2] == ~byte_ff[3]);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_address_byte    = out_byte_ff[0];
   assign rsp_address_inverse = out_byte_ff[1];
   assign rsp_command_byte    = out_byte_ff[2];
   assign rsp_command_inverse = out_byte_ff[3];
   assign rsp_command_ok      = ok_ff;

   `IRPDD_ASSERT_IMPLY(a_pos_bound, clock, reset, 1'b1, byte_pos_ff <= PosW'(FRAME_BYTES))
   `IRPDD_ASSERT_IMPLY(a_full_bit_clear, clock, reset, frame_full, bit_pos_ff == '0)
   `IRPDD_ASSERT_NEXT(a_emit_loads, clock, reset, emit, rsp_valid_ff && (byte_pos_ff == '0))

endmodule

FILE: rtl/ir_pulse_distance_decoder_unit.sv
// Top level of the IR pulse distance decoder.
// Accepts one capture stamp per cycle unless stalled. The front end compares each
// stamp with the previous one against the window registers in the cycle of the
// request, and queues the gap class in a two-entry queue; the frame engine applies
// one queued class per cycle unless a frame is held on a stalled rsp_ channel, and
// registers a decoded frame at the same edge. An end-pulse class goes to the queue
// first; on its pop the frame and rsp_valid are registered. Requests stall only
// while the queue is full, which happens when a finished frame waits on a stalled
// rsp_ channel. The first stamp after reset only primes the previous-stamp register.
module ir_pulse_distance_decoder_unit #(
   parameter int FRAME_BYTES = irpdd_pkg::FrameBytesDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [irpdd_pkg::StampW-1:0]   req_capture_stamp,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [irpdd_pkg::ByteW-1:0]    rsp_address_byte,
   output logic [irpdd_pkg::ByteW-1:0]    rsp_address_inverse,
   output logic [irpdd_pkg::ByteW-1:0]    rsp_command_byte,
   output logic [irpdd_pkg::ByteW-1:0]    rsp_command_inverse,
   output logic                           rsp_command_ok,
   input  logic                           csr_write,
   input  logic [irpdd_pkg::CfgIdxW-1:0]  csr_index,
   input  logic [irpdd_pkg::CfgW-1:0]     csr_wdata
);
   import irpdd_pkg::*;

   class_entry_type push;
   class_entry_type head;
   logic            pop;
   logic            q_full;
   logic            req_accept;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   irpdd_classifier u_classifier (
      .clock             (clock),
      .reset             (reset),
      .req_accept        (req_accept),
      .req_capture_stamp (req_capture_stamp),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .push              (push)
   );

   irpdd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   irpdd_frame #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_address_byte    (rsp_address_byte),
      .rsp_address_inverse (rsp_address_inverse),
      .rsp_command_byte    (rsp_command_byte),
      .rsp_command_inverse (rsp_command_inverse),
      .rsp_command_ok      (rsp_command_ok)
   );

endmodule
